// ----- hdl/hfla_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfla_pkg: handle free list allocator shared types
// Request codes, payload field widths and the control state encoding.
// ----------------------------------------------------------------------------
package hfla_pkg;

    // payload field widths
    localparam int HANDLE_IN_W  = 16;
    localparam int HANDLE_OUT_W = 8;
    localparam int KIND_FIELD_W = 4;
    localparam int KIND_MAX_W   = 8;

    // request codes
    typedef enum logic [1:0] {
        REQ_ACQUIRE   = 2'd0,
        REQ_RELEASE   = 2'd1,
        REQ_GET       = 2'd2,
        REQ_GET_CHECK = 2'd3
    } t_req_type;

    // control state, one-hot
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

endpackage

// ----- hdl/hfla_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfla_if: request and response channels
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface hfla_req_if;
    logic                                  valid;
    logic                                  ready;
    hfla_pkg::t_req_type                   req_type;
    logic signed [hfla_pkg::HANDLE_IN_W-1:0] handle_in;
    logic [hfla_pkg::KIND_FIELD_W-1:0]     entry_kind;

    modport source (output valid, output req_type, output handle_in,
                    output entry_kind, input ready);
    modport sink   (input valid, input req_type, input handle_in,
                    input entry_kind, output ready);
endinterface

interface hfla_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  success;
    logic [hfla_pkg::HANDLE_OUT_W-1:0]     handle_out;
    logic [hfla_pkg::KIND_FIELD_W-1:0]     kind_out;

    modport source (output valid, output success, output handle_out,
                    output kind_out, input ready);
    modport sink   (input valid, input success, input handle_out,
                    input kind_out, output ready);
endinterface

// ----- hdl/hfla_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfla_ram: generic simple dual-port ram
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module hfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hdl/handle_free_list_allocator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handle_free_list_allocator_unit: handle table with a lifo free list
// Acquire, release and lookup of handles; per-handle kind and free-list link
// live in one synchronous ram, head of list and high-water mark in registers.
// ----------------------------------------------------------------------------
// channel   dir  transfer when         payload
// i_req     in   valid && ready        req_type, handle_in, entry_kind
// o_rsp     out  valid && ready        success, handle_out, kind_out
//
// each request reads its table entry in idle, then updates it and loads the
// response register in execute; the registered ram read sets this split.
// a new request is taken while the previous response still waits in o_rsp.
// the execute cycle stalls only if the response register is still full.
// synchronous reset empties the free list and clears the high-water mark;
// no clearing pass, the table needs none.
// ----------------------------------------------------------------------------
module handle_free_list_allocator_unit #(
    parameter int CAPACITY  = 256,
    parameter int KIND_BITS = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    hfla_req_if.sink   i_req,
    hfla_rsp_if.source o_rsp
);
    import hfla_pkg::*;

    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int HW_W   = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (HW_W > HANDLE_IN_W) ? HW_W : HANDLE_IN_W;
    localparam int WORD_W = KIND_BITS + HW_W;
    localparam logic [HW_W-1:0] EMPTY_MARK = HW_W'(CAPACITY);

    // control and bookkeeping
    t_state                r_state;
    logic [HW_W-1:0]       r_free_head;
    logic [HW_W-1:0]       r_high_water;

    // captured request
    t_req_type             r_req;
    logic [KIND_BITS-1:0]  r_kind;
    logic [IDX_W-1:0]      r_addr;
    logic                  r_hvalid;
    logic                  r_acq_free;
    logic                  r_acq_new;

    // response register
    logic                  r_out_valid;
    logic                  r_success;
    logic [HANDLE_OUT_W-1:0] r_handle_out;
    logic [KIND_FIELD_W-1:0] r_kind_out;

    // ram ports
    logic                  wr_en;
    logic [WORD_W-1:0]     wr_data;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [WORD_W-1:0]     rd_data;
    logic [KIND_BITS-1:0]  rd_kind;
    logic [HW_W-1:0]       rd_link;

    // misc combinational
    logic                  accept;
    logic                  exec_go;
    logic                  head_nonempty;
    logic                  hw_room;
    logic                  handle_ok;
    logic [KIND_MAX_W-1:0] kind_in_ext;
    logic [KIND_BITS-1:0]  kind_in;
    logic [KIND_MAX_W-1:0] kind_rd_ext;
    logic                  live;

    logic                  n_success;
    logic [IDX_W-1:0]      n_handle;
    logic [KIND_FIELD_W-1:0] n_kind_out;
    logic [HW_W-1:0]       n_free_head;
    logic [HW_W-1:0]       n_high_water;

    // table ram: kind and free-list link per handle
    hfla_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_kind = rd_data[WORD_W-1:HW_W];
    assign rd_link = rd_data[HW_W-1:0];

    // handshake
    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign exec_go     = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);

    // request decode at the input
    assign head_nonempty = (r_free_head != EMPTY_MARK);
    assign hw_room       = (r_high_water < EMPTY_MARK);
    assign handle_ok     = !i_req.handle_in[HANDLE_IN_W-1] &&
                           (CMP_W'($unsigned(i_req.handle_in)) < CMP_W'(r_high_water));
    assign kind_in_ext   = KIND_MAX_W'(i_req.entry_kind);
    assign kind_in       = kind_in_ext[KIND_BITS-1:0];

    // read address: free-list head for acquire, queried handle otherwise
    always_comb begin
        if (i_req.req_type == REQ_ACQUIRE) begin
            rd_addr = r_free_head[IDX_W-1:0];
        end else begin
            rd_addr = i_req.handle_in[IDX_W-1:0];
        end
    end
    assign rd_en = accept;

    // capture the request
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req      <= i_req.req_type;
            r_kind     <= kind_in;
            r_hvalid   <= handle_ok;
            r_acq_free <= head_nonempty;
            r_acq_new  <= !head_nonempty && hw_room;
            if (i_req.req_type == REQ_ACQUIRE) begin
                r_addr <= head_nonempty ? r_free_head[IDX_W-1:0]
                                        : r_high_water[IDX_W-1:0];
            end else begin
                r_addr <= i_req.handle_in[IDX_W-1:0];
            end
        end
    end

    // execute: check, modify, write back
    assign live        = r_hvalid && (rd_kind != '0);
    assign kind_rd_ext = KIND_MAX_W'(rd_kind);

    always_comb begin
        n_success    = 1'b0;
        n_handle     = '0;
        n_kind_out   = '0;
        n_free_head  = r_free_head;
        n_high_water = r_high_water;
        wr_en        = 1'b0;
        wr_data      = {r_kind, EMPTY_MARK};
        unique case (r_req)
            REQ_ACQUIRE: begin
                if ((r_kind != '0) && (r_acq_free || r_acq_new)) begin
                    n_success = 1'b1;
                    n_handle  = r_addr;
                    wr_en     = exec_go;
                    wr_data   = {r_kind, EMPTY_MARK};
                    if (r_acq_free) begin
                        n_free_head = rd_link;
                    end else begin
                        n_high_water = r_high_water + 1'b1;
                    end
                end
            end
            REQ_RELEASE: begin
                if (live) begin
                    n_success   = 1'b1;
                    n_handle    = r_addr;
                    wr_en       = exec_go;
                    wr_data     = {{KIND_BITS{1'b0}}, r_free_head};
                    n_free_head = HW_W'(r_addr);
                end
            end
            REQ_GET: begin
                if (live) begin
                    n_success  = 1'b1;
                    n_handle   = r_addr;
                    n_kind_out = kind_rd_ext[KIND_FIELD_W-1:0];
                end
            end
            REQ_GET_CHECK: begin
                if (live && (rd_kind == r_kind)) begin
                    n_success  = 1'b1;
                    n_handle   = r_addr;
                    n_kind_out = kind_rd_ext[KIND_FIELD_W-1:0];
                end
            end
            default: ;
        endcase
    end

    // control state and bookkeeping registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_free_head  <= EMPTY_MARK;
            r_high_water <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (exec_go) begin
                        r_state      <= S_IDLE;
                        r_free_head  <= n_free_head;
                        r_high_water <= n_high_water;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_go) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_go) begin
            r_success    <= n_success;
            r_handle_out <= HANDLE_OUT_W'(n_handle);
            r_kind_out   <= n_kind_out;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.success    = r_success;
    assign o_rsp.handle_out = r_handle_out;
    assign o_rsp.kind_out   = r_kind_out;

`ifndef SYNTHESIS
    // high-water mark never passes the capacity
    a_hw_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_high_water <= EMPTY_MARK)
        else $error("high-water mark beyond capacity");

    // free-list head is empty or names a handle already handed out
    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_free_head == EMPTY_MARK) || (r_free_head < r_high_water))
        else $error("free-list head outside used range");

    // an accepted request moves to execute
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_EXEC))
        else $error("accepted request did not enter execute");

    // a response appears only after an execute cycle
    a_rsp_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_EXEC))
        else $error("response without execute");

    // table is written only while executing
    a_write_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == S_EXEC))
        else $error("table write outside execute");
`endif

endmodule
